[design/fsc_pkg.sv]
`timescale 1ns / 1ps

package fsc_pkg;

    // Characters the scanner looks for.
    localparam logic [7:0] CH_LPAREN = 8'h28;  // (
    localparam logic [7:0] CH_RPAREN = 8'h29;  // )
    localparam logic [7:0] CH_EQUAL  = 8'h3D;  // =
    localparam logic [7:0] CH_COMMA  = 8'h2C;  // ,
    localparam logic [7:0] CH_ZERO   = 8'h30;  // 0
    localparam logic [7:0] CH_NINE   = 8'h39;  // 9
    localparam logic [7:0] CH_SQUOTE = 8'h27;  // '
    localparam logic [7:0] CH_DQUOTE = 8'h22;  // "
    localparam logic [7:0] CH_D      = 8'h64;  // d
    localparam logic [7:0] CH_O      = 8'h6F;  // o
    localparam logic [7:0] CH_I      = 8'h69;  // i
    localparam logic [7:0] CH_F      = 8'h66;  // f
    localparam logic [7:0] CH_NONE   = 8'h00;  // no open quote

    // Character positions within the lead-in.
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_REST   = 2'd3;

    // Result queue between the scanner and the result side.
    localparam int QUEUE_ADDR_BITS = 2;
    localparam int QUEUE_DEPTH     = 1 << QUEUE_ADDR_BITS;

    typedef enum logic [1:0] {
        IF_NONE    = 2'd0,
        IF_ARITH   = 2'd1,
        IF_LOGICAL = 2'd2
    } t_if_kind;

    typedef struct packed {
        logic     keyword_first;
        t_if_kind if_kind;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_result_req;

endpackage

[design/fsc_scan.sv]
`timescale 1ns / 1ps

module fsc_scan
    import fsc_pkg::*;
#(
    parameter int DEPTH_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    output t_result_req o_req
);

    logic [1:0]            r_pos,     n_pos;
    logic [7:0]            r_first,   n_first;
    logic [7:0]            r_second,  n_second;
    logic                  r_is_do,   n_is_do;
    logic                  r_is_if,   n_is_if;
    logic [7:0]            r_quote,   n_quote;
    logic [DEPTH_BITS-1:0] r_depth,   n_depth;
    logic                  r_seen_eq, n_seen_eq;
    logic                  r_decided, n_decided;

    logic hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_FIRST;
            r_first   <= 8'h00;
            r_second  <= 8'h00;
            r_is_do   <= 1'b0;
            r_is_if   <= 1'b0;
            r_quote   <= CH_NONE;
            r_depth   <= '0;
            r_seen_eq <= 1'b0;
            r_decided <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_first   <= n_first;
            r_second  <= n_second;
            r_is_do   <= n_is_do;
            r_is_if   <= n_is_if;
            r_quote   <= n_quote;
            r_depth   <= n_depth;
            r_seen_eq <= n_seen_eq;
            r_decided <= n_decided;
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_first   = r_first;
        n_second  = r_second;
        n_is_do   = r_is_do;
        n_is_if   = r_is_if;
        n_quote   = r_quote;
        n_depth   = r_depth;
        n_seen_eq = r_seen_eq;
        n_decided = r_decided;
        hit       = 1'b0;
        o_req     = '{valid: 1'b0, data: '{keyword_first: 1'b0, if_kind: IF_NONE}};

        if (i_valid) begin
            if (!r_decided) begin
                case (r_pos)
                    POS_FIRST: begin
                        n_first = i_ch;
                    end
                    POS_SECOND: begin
                        n_second = i_ch;
                        if (r_first == CH_D && i_ch == CH_O) begin
                            n_is_do = 1'b1;
                        end
                    end
                    POS_THIRD: begin
                        if (r_first == CH_I && r_second == CH_F && i_ch == CH_LPAREN) begin
                            n_is_if = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase

                // A quote closes only on its own character; any other quote opens anew.
                if (i_ch == CH_SQUOTE || i_ch == CH_DQUOTE) begin
                    n_quote = (r_quote == i_ch) ? CH_NONE : i_ch;
                end

                if (n_quote == CH_NONE) begin
                    if (i_ch == CH_LPAREN) begin
                        if (r_depth != {DEPTH_BITS{1'b1}}) begin
                            n_depth = r_depth + 1'b1;
                        end
                    end else if (i_ch == CH_RPAREN) begin
                        if (r_depth != '0) begin
                            n_depth = r_depth - 1'b1;
                        end
                    end else if (!n_is_if && i_ch == CH_EQUAL && r_depth == '0) begin
                        if (n_is_do) begin
                            n_seen_eq = 1'b1;
                        end else begin
                            hit = 1'b1;
                            o_req.data.keyword_first = 1'b0;
                        end
                    end else if (n_is_do && r_seen_eq && i_ch == CH_COMMA
                                 && r_depth == '0) begin
                        hit = 1'b1;
                        o_req.data.keyword_first = 1'b1;
                    end else if (n_is_if && r_depth == '0 && r_pos == POS_REST) begin
                        hit = 1'b1;
                        o_req.data.keyword_first = 1'b1;
                        o_req.data.if_kind = (i_ch >= CH_ZERO && i_ch <= CH_NINE)
                                             ? IF_ARITH : IF_LOGICAL;
                    end
                end

                if (r_pos != POS_REST) begin
                    n_pos = r_pos + 2'd1;
                end

                if (hit) begin
                    n_decided   = 1'b1;
                    o_req.valid = 1'b1;
                end else if (i_last) begin
                    // No decision by the end: a DO without the comma is an assignment.
                    o_req.valid              = 1'b1;
                    o_req.data.keyword_first = !n_is_do;
                end
            end

            if (i_last) begin
                n_pos     = POS_FIRST;
                n_first   = 8'h00;
                n_second  = 8'h00;
                n_is_do   = 1'b0;
                n_is_if   = 1'b0;
                n_quote   = CH_NONE;
                n_depth   = '0;
                n_seen_eq = 1'b0;
                n_decided = 1'b0;
            end
        end
    end

endmodule

[design/fsc_queue.sv]
`timescale 1ns / 1ps

module fsc_queue
    import fsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_result_req i_req,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_result     o_data
);

    t_result                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_ADDR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_ADDR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_ADDR_BITS:0]   r_count,  n_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QUEUE_ADDR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_req.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req.data;
        end
    end

endmodule

[design/fortran_statement_classifier_top.sv]
`timescale 1ns / 1ps

// Fortran statement classifier.
// Characters of one statement arrive on the input queue interface, one per
// request: i_ch carries the lower-case character and i_last marks the final
// character. A request is taken on a rising edge with push high and full low.
// Each statement yields exactly one result, either at the point where the
// first token is decided (assignment, DO, arithmetic or logical IF) or at the
// last character. Results wait in a four-entry queue and are read through
// empty and pop: the oldest result sits on o_keyword_first and o_if_kind
// while empty is low and leaves on an edge with pop high and empty low.
// The scanner takes one character every cycle while full is low; its
// per-character update is a few compares and one saturating depth step. A
// result enters the queue on the same edge that takes the character behind it.
// When the receiver stalls, results collect in the queue and full rises once
// four are waiting; characters that cause no result are still held back then.
// A synchronous active-low reset empties the queue and clears the scan state,
// so the next character is taken as the first of a new statement.
module fortran_statement_classifier_top
    import fsc_pkg::*;
#(
    parameter int DEPTH_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       empty,
    input  logic       pop,
    output logic       o_keyword_first,
    output logic [1:0] o_if_kind
);

    t_result_req scan_req;
    t_result     head;
    logic        accept;

    // The scanner only advances when the queue can take whatever it emits.
    assign accept = push && !full;

    fsc_scan #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_ch    (i_ch),
        .i_last  (i_last),
        .o_req   (scan_req)
    );

    fsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scan_req),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (head)
    );

    assign o_keyword_first = head.keyword_first;
    assign o_if_kind       = head.if_kind;

    // A result is produced only for a character actually taken.
    a_result_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_req.valid |-> accept)
        else $error("result produced without an accepted character");

    // Once full, the queue stays full until a pop. No result is lost: the final
    // character of an undecided statement always produces one.
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full && !pop |=> full)
        else $error("queue left the full state without a pop");

    // A result at the head never carries the unused if_kind code.
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_if_kind != 2'd3))
        else $error("illegal if_kind at queue head");

    // Only a keyword statement can be an IF.
    a_if_is_keyword: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_if_kind != 2'd0) |-> o_keyword_first)
        else $error("IF result without keyword_first");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

// Testbench for the Fortran statement classifier.
// Statements are sent one character per request through the push/full side.
// A scan model kept in this file follows every accepted character and queues
// the result that the statement is expected to produce. A separate process
// pops results on a stall pattern of its own and compares each one, field by
// field, with the oldest queued expectation. Directed statements come first,
// then one statement that drives the parenthesis depth into its top limit,
// and then random statements, most of them well formed.
module tb;
    import fsc_pkg::*;

    localparam int TB_DEPTH_BITS = 8;
    localparam int DEPTH_LIMIT   = (1 << TB_DEPTH_BITS) - 1;
    localparam int LIVE_TARGET   = 1550;

    // Receiver behaviors, one chosen per segment of cycles.
    typedef enum int {
        RX_STREAM,
        RX_COIN,
        RX_SLOW,
        RX_PATTERN
    } t_rx_mode;

    // Shapes of random statements.
    typedef enum int {
        ST_ASSIGN,
        ST_DO,
        ST_IF,
        ST_LEAD_IN,
        ST_NOISE
    } t_stmt_kind;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_ch = 8'h00;
    logic       i_last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic       o_keyword_first;
    logic [1:0] o_if_kind;

    fortran_statement_classifier_top #(
        .DEPTH_BITS(TB_DEPTH_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_ch            (i_ch),
        .i_last          (i_last),
        .empty           (empty),
        .pop             (pop),
        .o_keyword_first (o_keyword_first),
        .o_if_kind       (o_if_kind)
    );

    always #5 i_clk = ~i_clk;

    // State of the scan model. It mirrors what the block keeps per statement.
    logic [1:0]               sc_pos = POS_FIRST;
    logic [7:0]               sc_first = 8'h00;
    logic [7:0]               sc_second = 8'h00;
    logic                     sc_do = 1'b0;
    logic                     sc_if = 1'b0;
    logic [7:0]               sc_quote = CH_NONE;
    logic [TB_DEPTH_BITS-1:0] sc_depth = '0;
    logic                     sc_equal = 1'b0;
    logic                     sc_done = 1'b0;

    // Classifications that the block still owes, oldest first.
    t_result    pending_results[$];
    int         fail_count = 0;
    int         live_count = 0;
    logic       idle_on = 1'b1;
    int         burst_left = 0;
    logic [7:0] stmt_buf[$];

    function automatic void clear_scan();
        sc_pos    = POS_FIRST;
        sc_first  = 8'h00;
        sc_second = 8'h00;
        sc_do     = 1'b0;
        sc_if     = 1'b0;
        sc_quote  = CH_NONE;
        sc_depth  = '0;
        sc_equal  = 1'b0;
        sc_done   = 1'b0;
    endfunction

    // Advances the scan model by one character. Returns 1 when the character
    // produces a classification, which is then given in kw and kind.
    function automatic logic classify_char(input logic [7:0] c, input logic fin,
                                           output logic kw, output t_if_kind kind);
        logic hit;
        hit  = 1'b0;
        kw   = 1'b0;
        kind = IF_NONE;
        if (!sc_done) begin
            case (sc_pos)
                POS_FIRST: sc_first = c;
                POS_SECOND: begin
                    sc_second = c;
                    if (sc_first == CH_D && c == CH_O) sc_do = 1'b1;
                end
                POS_THIRD: begin
                    if (sc_first == CH_I && sc_second == CH_F && c == CH_LPAREN)
                        sc_if = 1'b1;
                end
                default: ;
            endcase

            // A quote that does not match the open one opens a new quote.
            if (c == CH_SQUOTE || c == CH_DQUOTE)
                sc_quote = (sc_quote == c) ? CH_NONE : c;

            if (sc_quote == CH_NONE) begin
                if (c == CH_LPAREN) begin
                    if (sc_depth < DEPTH_LIMIT) sc_depth = sc_depth + 1'b1;
                end else if (c == CH_RPAREN) begin
                    if (sc_depth > 0) sc_depth = sc_depth - 1'b1;
                end else if (!sc_if && c == CH_EQUAL && sc_depth == 0) begin
                    if (sc_do) begin
                        sc_equal = 1'b1;
                    end else begin
                        hit = 1'b1;
                    end
                end else if (sc_do && sc_equal && c == CH_COMMA && sc_depth == 0) begin
                    kw  = 1'b1;
                    hit = 1'b1;
                end else if (sc_if && sc_depth == 0 && sc_pos == POS_REST) begin
                    kw   = 1'b1;
                    kind = (c >= CH_ZERO && c <= CH_NINE) ? IF_ARITH : IF_LOGICAL;
                    hit  = 1'b1;
                end
            end

            if (sc_pos != POS_REST) sc_pos = sc_pos + 1'b1;

            if (hit) begin
                sc_done = 1'b1;
            end else if (fin) begin
                // The statement ended undecided: only a DO counts as an assignment.
                hit  = 1'b1;
                kw   = !sc_do;
                kind = IF_NONE;
            end
        end
        if (fin) clear_scan();
        return hit;
    endfunction

    // Sends one character and waits until the block takes it. The sender then
    // either keeps push high for the next request or opens a gap.
    task automatic send_char(input logic [7:0] c, input logic fin);
        logic     kw;
        t_if_kind kind;
        int       gap;
        @(negedge i_clk);
        push   <= 1'b1;
        i_ch   <= c;
        i_last <= fin;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        live_count++;
        if (classify_char(c, fin, kw, kind))
            pending_results.push_back('{keyword_first: kw, if_kind: kind});
        if (idle_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(1, 10);
                @(negedge i_clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Sends the statement held in stmt_buf, marking its final character.
    task automatic send_stmt();
        for (int i = 0; i < stmt_buf.size(); i++)
            send_char(stmt_buf[i], i == stmt_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        stmt_buf.delete();
        for (int i = 0; i < s.len(); i++) stmt_buf.push_back(s[i]);
        send_stmt();
    endtask

    function automatic logic [7:0] pick_letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Characters weighted toward the ones that steer the scan.
    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0:       c = CH_LPAREN;
            1:       c = CH_RPAREN;
            2:       c = CH_EQUAL;
            3:       c = CH_COMMA;
            4:       c = CH_SQUOTE;
            5:       c = CH_DQUOTE;
            6, 7:    c = pick_digit();
            8:       c = 8'($urandom_range(0, 255));
            default: c = pick_letter();
        endcase
        return c;
    endfunction

    function automatic void add_tail(input int max_len);
        int n;
        n = $urandom_range(0, max_len);
        repeat (n) stmt_buf.push_back(pick_char());
    endfunction

    // Builds one random statement in stmt_buf.
    function automatic void make_statement();
        string      lead_ins[6];
        t_stmt_kind kind;
        int         roll;
        lead_ins = '{"d", "do", "i", "if", "if(", "df"};
        roll = $urandom_range(0, 99);
        if (roll < 25)      kind = ST_ASSIGN;
        else if (roll < 45) kind = ST_DO;
        else if (roll < 70) kind = ST_IF;
        else if (roll < 90) kind = ST_LEAD_IN;
        else                kind = ST_NOISE;
        stmt_buf.delete();
        case (kind)
            ST_ASSIGN: begin
                stmt_buf.push_back(pick_letter());
                if ($urandom_range(0, 2) == 0) begin
                    stmt_buf.push_back(CH_LPAREN);
                    stmt_buf.push_back(pick_digit());
                    stmt_buf.push_back(CH_RPAREN);
                end
                stmt_buf.push_back(CH_EQUAL);
                add_tail(6);
            end
            ST_DO: begin
                stmt_buf.push_back(CH_D);
                stmt_buf.push_back(CH_O);
                stmt_buf.push_back(pick_letter());
                if ($urandom_range(0, 3) == 0) add_tail(3);
                stmt_buf.push_back(CH_EQUAL);
                stmt_buf.push_back(pick_digit());
                stmt_buf.push_back(CH_COMMA);
                add_tail(5);
            end
            ST_IF: begin
                stmt_buf.push_back(CH_I);
                stmt_buf.push_back(CH_F);
                stmt_buf.push_back(CH_LPAREN);
                add_tail(4);
                stmt_buf.push_back(CH_RPAREN);
                stmt_buf.push_back($urandom_range(0, 1) ? pick_digit() : pick_char());
                add_tail(5);
            end
            ST_LEAD_IN: begin
                roll = $urandom_range(0, 5);
                for (int i = 0; i < lead_ins[roll].len(); i++)
                    stmt_buf.push_back(lead_ins[roll][i]);
                add_tail(8);
            end
            default: begin
                repeat ($urandom_range(1, 6)) stmt_buf.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    // Every popped result must match the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: keyword_first %0b if_kind %0d",
                         $time, o_keyword_first, o_if_kind);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_keyword_first !== want.keyword_first) begin
                    $display("%0t: keyword_first expected %0b actual %0b",
                             $time, want.keyword_first, o_keyword_first);
                    fail_count++;
                end
                if (o_if_kind !== want.if_kind) begin
                    $display("%0t: if_kind expected %0d actual %0d",
                             $time, want.if_kind, o_if_kind);
                    fail_count++;
                end
            end
        end
    end

    // The receiver works in segments, each with its own way of stalling, so
    // that stalls land on every phase of the scan and the queue fills up now
    // and then.
    initial begin
        int         seg;
        t_rx_mode   mode;
        logic [7:0] mask;
        forever begin
            seg  = $urandom_range(1, 60);
            mode = t_rx_mode'($urandom_range(0, 3));
            mask = 8'($urandom_range(0, 255));
            repeat (seg) begin
                @(negedge i_clk);
                case (mode)
                    RX_STREAM: pop <= 1'b1;
                    RX_COIN:   pop <= 1'($urandom_range(0, 1));
                    RX_SLOW:   pop <= ($urandom_range(0, 5) == 0);
                    default: begin
                        pop <= mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                endcase
            end
        end
    end

    // The extreme character codes, each as a one-character statement, and
    // the statement "do", which ends right after its lead-in.
    task automatic test_field_extremes();
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        send_text("do");
    endtask

    // A plain assignment decides at its exposed '='; the rest is ignored.
    task automatic test_assignment();
        send_text("a=b");
    endtask

    // A DO decides at the exposed ',' after an exposed '='.
    task automatic test_do_loop();
        send_text("do=,");
    endtask

    // The first character after the IF condition closes tells the IF kind.
    task automatic test_if_forms();
        send_text("if()1");
        send_text("if()x");
    endtask

    // A closing ')' at depth zero stays at zero. Quotes hide '=' until they
    // close, and an unclosed quote leaves the statement undecided.
    task automatic test_quotes_and_floor();
        send_text(")=");
        send_text("'a'=");
        send_text("'=");
    endtask

    // Drives the depth past its top limit inside an IF condition. With the
    // depth held at the limit the closing parentheses bring it back to zero
    // just before the digit, which makes this an arithmetic IF.
    task automatic test_depth_ceiling();
        stmt_buf.delete();
        stmt_buf.push_back(CH_I);
        stmt_buf.push_back(CH_F);
        stmt_buf.push_back(CH_LPAREN);
        repeat (DEPTH_LIMIT) stmt_buf.push_back(CH_LPAREN);
        repeat (DEPTH_LIMIT - 1) stmt_buf.push_back(CH_RPAREN);
        stmt_buf.push_back(pick_letter());
        stmt_buf.push_back(CH_RPAREN);
        stmt_buf.push_back(pick_digit());
        send_stmt();
    endtask

    // Random statements until enough characters have been sent. Idling is
    // switched off for stretches so that back-to-back traffic is covered too.
    task automatic test_random_statements();
        int n;
        n = 0;
        while (live_count < LIVE_TARGET) begin
            if (n % 20 == 0) idle_on = ($urandom_range(0, 3) != 0);
            make_statement();
            send_stmt();
            n++;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_assignment();
        test_do_loop();
        test_if_forms();
        test_quotes_and_floor();
        test_depth_ceiling();
        test_random_statements();

        // Lower push so that the last character is not taken twice.
        @(negedge i_clk);
        push <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0 && pending_results.size() == 0 && empty) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: a correct run needs a small part of this time.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
